/* hw/rtl/two_level_page_table_engine_defines.svh */
// assertion macros for the two-level page table engine
// users must have clk and rst_n in scope; no other dependencies
`ifndef TWO_LEVEL_PAGE_TABLE_ENGINE_DEFINES_SVH
`define TWO_LEVEL_PAGE_TABLE_ENGINE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TLPT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define TLPT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/tlpt_pkg.sv */
// shared types, codes and constants of the two-level page table engine
// no dependencies
package tlpt_pkg;

  localparam int unsigned TABLE_SLOTS_DEF = 16;
  localparam int unsigned DIR_ENTRIES     = 1024;
  localparam int unsigned IDX_W           = 10;
  localparam int unsigned VPAGE_W         = 20;
  localparam int unsigned FRAME_W         = 20;
  localparam int unsigned FLAG_W          = 12;
  localparam int unsigned ENTRY_W         = 32;

  localparam logic [FLAG_W-1:0] ENTRY_P       = 12'h001;
  localparam logic [FLAG_W-1:0] ENTRY_PS      = 12'h080;
  localparam logic [FLAG_W-1:0] DIR_FLAG_MASK = 12'h03F;

  // request kinds; the third and fourth codes act as translate
  localparam logic [1:0] KIND_MAP   = 2'd0;
  localparam logic [1:0] KIND_UNMAP = 2'd1;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NOT_PRESENT = 2'd1,
    ST_NO_TABLE    = 2'd2,
    ST_CONFLICT    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    MT_NONE  = 2'd0,
    MT_SMALL = 2'd1,
    MT_LARGE = 2'd2
  } mtype_t;

  typedef enum logic [2:0] {
    DS_ZERO  = 3'd0,
    DS_LARGE = 3'd1,
    DS_SMALL = 3'd2,
    DS_NEW   = 3'd3,
    DS_UNMAP = 3'd4
  } dir_src_t;

  typedef enum logic [1:0] {
    TS_ZERO  = 2'd0,
    TS_MAP   = 2'd1,
    TS_NEW   = 2'd2,
    TS_UNMAP = 2'd3
  } tbl_src_t;

  typedef struct packed {
    logic     req_load;
    logic     cnt_inc;
    logic     dir_we;
    dir_src_t dir_src;
    logic     dir_sweep;
    logic     tbl_we;
    tbl_src_t tbl_src;
    logic     tbl_fresh;
    logic     alloc;
    logic     out_load;
    status_t  out_status;
    mtype_t   out_mtype;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       large_pg;
    logic       pde_p;
    logic       pde_ps;
    logic       slot_ok;
    logic       pool_full;
    logic       te_p;
    logic       cnt_last;
    logic       out_free;
  } sts_t;

endpackage

/* hw/rtl/tlpt_req_if.sv */
// request channel: valid/ready handshake with the request fields
// depends on tlpt_pkg for field widths
interface tlpt_req_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    kind;
  logic [tlpt_pkg::VPAGE_W-1:0]  virt_page;
  logic [tlpt_pkg::FRAME_W-1:0]  phys_frame;
  logic [tlpt_pkg::FLAG_W-1:0]   flags;
  logic                          large_page;

  modport source (output valid, kind, virt_page, phys_frame, flags, large_page, input ready);
  modport sink (input valid, kind, virt_page, phys_frame, flags, large_page, output ready);
endinterface

/* hw/rtl/tlpt_rsp_if.sv */
// result channel: valid/ready handshake with the result fields
// depends on tlpt_pkg for field widths and codes
interface tlpt_rsp_if;
  logic                         valid;
  logic                         ready;
  tlpt_pkg::status_t            status;
  tlpt_pkg::mtype_t             map_type;
  logic [tlpt_pkg::FRAME_W-1:0] frame_out;

  modport source (output valid, status, map_type, frame_out, input ready);
  modport sink (input valid, status, map_type, frame_out, output ready);
endinterface

/* hw/rtl/tlpt_ram.sv */
// generic single-write, single-read ram with registered read data
// read during write to the same address returns the old word; no dependencies
module tlpt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/tlpt_ctrl.sv */
// sequencer of the page table engine: walks each request through the
// directory and table reads, table clearing and write-back; uses tlpt_pkg
module tlpt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  tlpt_pkg::sts_t sts,
  output tlpt_pkg::cmd_t cmd
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EVAL,
    S_TBL,
    S_CLR,
    S_NEW,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  tlpt_pkg::status_t st_r, st_nxt;
  tlpt_pkg::mtype_t  mt_r, mt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      st_r    <= tlpt_pkg::ST_OK;
      mt_r    <= tlpt_pkg::MT_NONE;
    end else begin
      state_r <= state_nxt;
      st_r    <= st_nxt;
      mt_r    <= mt_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    st_nxt         = st_r;
    mt_nxt         = mt_r;
    cmd            = '0;
    cmd.dir_src    = tlpt_pkg::DS_ZERO;
    cmd.tbl_src    = tlpt_pkg::TS_ZERO;
    cmd.out_status = st_r;
    cmd.out_mtype  = mt_r;
    unique case (state_r)
      S_INIT: begin
        // zero the directory, one entry per cycle
        cmd.dir_we    = 1'b1;
        cmd.dir_sweep = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.req_load = 1'b1;
          st_nxt       = tlpt_pkg::ST_OK;
          mt_nxt       = tlpt_pkg::MT_NONE;
          state_nxt    = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_DONE;
        unique case (sts.kind)
          tlpt_pkg::KIND_MAP: begin
            if (sts.large_pg) begin
              cmd.dir_we  = 1'b1;
              cmd.dir_src = tlpt_pkg::DS_LARGE;
            end else if (sts.pde_p && sts.pde_ps) begin
              st_nxt = tlpt_pkg::ST_CONFLICT;
            end else if (!sts.pde_p) begin
              if (sts.pool_full) begin
                st_nxt = tlpt_pkg::ST_NO_TABLE;
              end else begin
                state_nxt = S_CLR;
              end
            end else begin
              state_nxt = S_TBL;
            end
          end
          tlpt_pkg::KIND_UNMAP: begin
            if (!sts.pde_p) begin
              st_nxt = tlpt_pkg::ST_NOT_PRESENT;
            end else if (sts.pde_ps) begin
              if (sts.large_pg) begin
                cmd.dir_we  = 1'b1;
                cmd.dir_src = tlpt_pkg::DS_UNMAP;
              end else begin
                st_nxt = tlpt_pkg::ST_CONFLICT;
              end
            end else if (!sts.slot_ok) begin
              st_nxt = tlpt_pkg::ST_NOT_PRESENT;
            end else begin
              state_nxt = S_TBL;
            end
          end
          default: begin
            if (!sts.pde_p) begin
              st_nxt = tlpt_pkg::ST_NOT_PRESENT;
            end else if (sts.pde_ps) begin
              mt_nxt = tlpt_pkg::MT_LARGE;
            end else if (!sts.slot_ok) begin
              st_nxt = tlpt_pkg::ST_NOT_PRESENT;
            end else begin
              state_nxt = S_TBL;
            end
          end
        endcase
      end
      S_TBL: begin
        // table entry read data is valid here
        state_nxt = S_DONE;
        unique case (sts.kind)
          tlpt_pkg::KIND_MAP: begin
            cmd.dir_we  = 1'b1;
            cmd.dir_src = tlpt_pkg::DS_SMALL;
            cmd.tbl_we  = sts.slot_ok;
            cmd.tbl_src = tlpt_pkg::TS_MAP;
          end
          tlpt_pkg::KIND_UNMAP: begin
            if (sts.te_p) begin
              cmd.tbl_we  = 1'b1;
              cmd.tbl_src = tlpt_pkg::TS_UNMAP;
            end else begin
              st_nxt = tlpt_pkg::ST_NOT_PRESENT;
            end
          end
          default: begin
            if (sts.te_p) begin
              mt_nxt = tlpt_pkg::MT_SMALL;
            end else begin
              st_nxt = tlpt_pkg::ST_NOT_PRESENT;
            end
          end
        endcase
      end
      S_CLR: begin
        // zero the freshly allocated table, one entry per cycle
        cmd.tbl_we    = 1'b1;
        cmd.tbl_src   = tlpt_pkg::TS_ZERO;
        cmd.tbl_fresh = 1'b1;
        cmd.cnt_inc   = 1'b1;
        if (sts.cnt_last) begin
          state_nxt = S_NEW;
        end
      end
      S_NEW: begin
        cmd.dir_we    = 1'b1;
        cmd.dir_src   = tlpt_pkg::DS_NEW;
        cmd.tbl_we    = 1'b1;
        cmd.tbl_src   = tlpt_pkg::TS_NEW;
        cmd.tbl_fresh = 1'b1;
        cmd.alloc     = 1'b1;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

endmodule

/* hw/rtl/tlpt_dpath.sv */
// datapath of the page table engine: request registers, directory and
// table rams, slot allocator, entry update logic and result register; uses tlpt_pkg
module tlpt_dpath #(
  parameter int unsigned TABLE_SLOTS = tlpt_pkg::TABLE_SLOTS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [1:0]                   in_kind,
  input  logic [tlpt_pkg::VPAGE_W-1:0] in_virt_page,
  input  logic [tlpt_pkg::FRAME_W-1:0] in_phys_frame,
  input  logic [tlpt_pkg::FLAG_W-1:0]  in_flags,
  input  logic                         in_large_page,
  output logic                         out_valid,
  input  logic                         out_ready,
  output tlpt_pkg::status_t            out_status,
  output tlpt_pkg::mtype_t             out_map_type,
  output logic [tlpt_pkg::FRAME_W-1:0] out_frame_out,
  input  tlpt_pkg::cmd_t               cmd,
  output tlpt_pkg::sts_t               sts
);

  localparam int unsigned IDX_W     = tlpt_pkg::IDX_W;
  localparam int unsigned FRAME_W   = tlpt_pkg::FRAME_W;
  localparam int unsigned FLAG_W    = tlpt_pkg::FLAG_W;
  localparam int unsigned ENTRY_W   = tlpt_pkg::ENTRY_W;
  localparam int unsigned SLOT_W    = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned NFT_W     = $clog2(TABLE_SLOTS + 1);
  localparam int unsigned TBL_DEPTH = TABLE_SLOTS * tlpt_pkg::DIR_ENTRIES;
  localparam int unsigned TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

  // request registers
  logic [1:0]         kind_r;
  logic [IDX_W-1:0]   di_r, ti_r;
  logic [FRAME_W-1:0] frame_r;
  logic [FLAG_W-1:0]  flags_r;
  logic               large_r;

  logic [IDX_W-1:0]   cnt_r;
  logic [NFT_W-1:0]   nft_r;

  logic               out_valid_r, out_valid_nxt;
  tlpt_pkg::status_t  out_status_r;
  tlpt_pkg::mtype_t   out_mtype_r;
  logic [FRAME_W-1:0] out_frame_r, frame_sel;

  logic [ENTRY_W-1:0] pde, te, dir_wdata, tbl_wdata;
  logic [IDX_W-1:0]   dir_waddr, dir_raddr, tbl_ti;
  logic [FLAG_W-1:0]  fl;
  logic [SLOT_W-1:0]  tbl_slot;
  logic [SLOT_W+IDX_W-1:0] tbl_full;
  logic [TBL_AW-1:0]  tbl_addr;

  always_ff @(posedge clk) begin
    if (cmd.req_load) begin
      kind_r  <= in_kind;
      di_r    <= in_virt_page[2*IDX_W-1:IDX_W];
      ti_r    <= in_virt_page[IDX_W-1:0];
      frame_r <= in_phys_frame;
      flags_r <= in_flags;
      large_r <= in_large_page;
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_mtype_r  <= cmd.out_mtype;
      out_frame_r  <= frame_sel;
    end
  end

  assign out_valid_nxt = cmd.out_load | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      nft_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.cnt_inc) begin
        cnt_r <= cnt_r + IDX_W'(1);
      end
      if (cmd.alloc) begin
        nft_r <= nft_r + NFT_W'(1);
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  assign fl = flags_r | tlpt_pkg::ENTRY_P;

  // directory: read address comes straight from the bus on acceptance
  assign dir_raddr = cmd.req_load ? in_virt_page[2*IDX_W-1:IDX_W] : di_r;
  assign dir_waddr = cmd.dir_sweep ? cnt_r : di_r;

  always_comb begin
    case (cmd.dir_src)
      tlpt_pkg::DS_LARGE:
        dir_wdata = {frame_r, pde[FLAG_W-1:0] | fl | tlpt_pkg::ENTRY_PS};
      tlpt_pkg::DS_SMALL:
        dir_wdata = {pde[ENTRY_W-1:FLAG_W],
                     pde[FLAG_W-1:0] | (fl & tlpt_pkg::DIR_FLAG_MASK)};
      tlpt_pkg::DS_NEW:
        dir_wdata = {FRAME_W'(nft_r),
                     ((pde[FLAG_W-1:0] | tlpt_pkg::ENTRY_P) & ~tlpt_pkg::ENTRY_PS)
                     | (fl & tlpt_pkg::DIR_FLAG_MASK)};
      tlpt_pkg::DS_UNMAP:
        dir_wdata = {pde[ENTRY_W-1:FLAG_W], pde[FLAG_W-1:0] & ~tlpt_pkg::ENTRY_P};
      default:
        dir_wdata = '0;
    endcase
  end

  tlpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (tlpt_pkg::DIR_ENTRIES)
  ) u_dir_ram (
    .clk   (clk),
    .we    (cmd.dir_we),
    .waddr (dir_waddr),
    .wdata (dir_wdata),
    .raddr (dir_raddr),
    .rdata (pde)
  );

  // table store address: slot from the directory entry, or the slot being handed out
  assign tbl_slot = cmd.tbl_fresh ? nft_r[SLOT_W-1:0] : pde[FLAG_W +: SLOT_W];
  assign tbl_ti   = (cmd.tbl_fresh && cmd.tbl_src == tlpt_pkg::TS_ZERO) ? cnt_r : ti_r;
  assign tbl_full = {tbl_slot, tbl_ti};
  assign tbl_addr = tbl_full[TBL_AW-1:0];

  always_comb begin
    case (cmd.tbl_src)
      tlpt_pkg::TS_MAP:   tbl_wdata = {frame_r, te[FLAG_W-1:0] | fl};
      tlpt_pkg::TS_NEW:   tbl_wdata = {frame_r, fl};
      tlpt_pkg::TS_UNMAP: tbl_wdata = {te[ENTRY_W-1:FLAG_W], te[FLAG_W-1:0] & ~tlpt_pkg::ENTRY_P};
      default:            tbl_wdata = '0;
    endcase
  end

  tlpt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TBL_DEPTH)
  ) u_tbl_ram (
    .clk   (clk),
    .we    (cmd.tbl_we),
    .waddr (tbl_addr),
    .wdata (tbl_wdata),
    .raddr (tbl_addr),
    .rdata (te)
  );

  always_comb begin
    case (cmd.out_mtype)
      tlpt_pkg::MT_LARGE: frame_sel = pde[ENTRY_W-1:FLAG_W];
      tlpt_pkg::MT_SMALL: frame_sel = te[ENTRY_W-1:FLAG_W];
      default:            frame_sel = '0;
    endcase
  end

  assign sts.kind      = kind_r;
  assign sts.large_pg  = large_r;
  assign sts.pde_p     = pde[0];
  assign sts.pde_ps    = pde[7];
  assign sts.slot_ok   = (pde[ENTRY_W-1:FLAG_W] < FRAME_W'(TABLE_SLOTS));
  assign sts.pool_full = (nft_r == NFT_W'(TABLE_SLOTS));
  assign sts.te_p      = te[0];
  assign sts.cnt_last  = (cnt_r == {IDX_W{1'b1}});
  assign sts.out_free  = ~out_valid_r | out_ready;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_map_type  = out_mtype_r;
  assign out_frame_out = out_frame_r;

endmodule

/* hw/rtl/two_level_page_table_engine.sv */
// channel   dir  handshake     payload
// in_ch     in   valid/ready   kind, virt_page, phys_frame, flags, large_page
// out_ch    out  valid/ready   status, map_type, frame_out
//
// one request in flight; an item that needs only the directory entry passes EVAL
// and DONE, one that reads the table entry also TBL (one registered ram read each)
// a small map that hands out a new table first zeroes that table one word per
// cycle through the table ram's single write port
// after reset the directory is zeroed, with in_ch.ready low
// a result waiting on out_ch does not block acceptance; the next one waits
// for the result register to drain
// depends on tlpt_pkg, tlpt_req_if, tlpt_rsp_if, tlpt_ctrl, tlpt_dpath and the defines header
`include "two_level_page_table_engine_defines.svh"

module two_level_page_table_engine #(
  parameter int unsigned TABLE_SLOTS = tlpt_pkg::TABLE_SLOTS_DEF
) (
  input logic        clk,
  input logic        rst_n,
  tlpt_req_if.sink   in_ch,
  tlpt_rsp_if.source out_ch
);

  tlpt_pkg::cmd_t cmd;
  tlpt_pkg::sts_t sts;

  tlpt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tlpt_dpath #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_dpath (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_kind       (in_ch.kind),
    .in_virt_page  (in_ch.virt_page),
    .in_phys_frame (in_ch.phys_frame),
    .in_flags      (in_ch.flags),
    .in_large_page (in_ch.large_page),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_status    (out_ch.status),
    .out_map_type  (out_ch.map_type),
    .out_frame_out (out_ch.frame_out),
    .cmd           (cmd),
    .sts           (sts)
  );

  // one item at a time: the engine is busy right after an acceptance
  `TLPT_ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready,
    "engine ready again right after accepting an item")

  // the allocator never hands out a slot past the pool
  `TLPT_ASSERT_NOW(a_alloc_in_pool, cmd.alloc, !sts.pool_full,
    "table slot allocated from an exhausted pool")

  // a result is never loaded over one still waiting
  `TLPT_ASSERT_NOW(a_no_result_overwrite, cmd.out_load, sts.out_free,
    "result register overwritten before it was taken")

  // neither ram is written on the cycle an item is accepted
  `TLPT_ASSERT_NOW(a_no_write_on_accept, in_ch.valid && in_ch.ready,
    !cmd.dir_we && !cmd.tbl_we, "ram written while accepting an item")

endmodule

/* test/two_level_page_table_engine_tb.sv */
// self-checking testbench for the two-level page table engine
// drives map, unmap and translate requests and checks every result against an in-bench model
// depends on tlpt_pkg, tlpt_req_if, tlpt_rsp_if and the engine rtl
`timescale 1ns / 100ps

module two_level_page_table_engine_tb;
  import tlpt_pkg::*;

  localparam int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF;
  localparam logic [1:0] KIND_XLATE     = 2'd2;
  localparam logic [1:0] KIND_XLATE_ALT = 2'd3;

  localparam int unsigned REQ_TOTAL   = 420;
  localparam int unsigned BURST_LO    = 80;
  localparam int unsigned BURST_HI    = 140;
  localparam int unsigned HOLD_AT     = 100;
  localparam int unsigned SETTLE_AT   = 260;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned RX_CALM_LO  = 180;
  localparam int unsigned RX_CALM_HI  = 240;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam int unsigned TAIL_CYCLES = 20;

  typedef struct {
    logic [1:0]         kind;
    logic [VPAGE_W-1:0] vpage;
    logic [FRAME_W-1:0] frame;
    logic [FLAG_W-1:0]  flags;
    logic               large_pg;
    int unsigned        gap;
    bit                 settle;
    bit                 hold_rx;
  } page_req_t;

  typedef struct {
    status_t            status;
    mtype_t             mtype;
    logic [FRAME_W-1:0] frame;
  } walk_result_t;

  logic clk;
  logic rst_n;

  tlpt_req_if req_if ();
  tlpt_rsp_if rsp_if ();

  two_level_page_table_engine dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (rsp_if)
  );

  // page table model
  bit [ENTRY_W-1:0] dir_model [DIR_ENTRIES];
  bit [ENTRY_W-1:0] tbl_model [TABLE_SLOTS*DIR_ENTRIES];
  int unsigned      slots_taken = 0;

  page_req_t    page_reqs [$];
  walk_result_t walk_results [$];

  page_req_t    cur;
  page_req_t    seen_req;
  walk_result_t want;
  walk_result_t got;

  bit          req_taken = 1'b0;
  bit          rsp_taken = 1'b0;
  int unsigned idle_gap = 0;
  int unsigned rx_wait = 0;
  int unsigned hold_kick = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned results_seen = 0;
  int unsigned quiet_cycles = 0;
  int unsigned err_count = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string what);
    err_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // walks the model tables for one request and applies its side effects
  task automatic walk_request(input page_req_t r, output walk_result_t res);
    logic [IDX_W-1:0]   di;
    logic [IDX_W-1:0]   ti;
    logic [ENTRY_W-1:0] pde;
    logic [ENTRY_W-1:0] te;
    logic [FLAG_W-1:0]  fl;
    bit                 pde_p;
    bit                 pde_ps;
    bit                 slot_ok;
    bit                 te_p;
    int unsigned        slot;
    int unsigned        idx;
    di = r.vpage[VPAGE_W-1:IDX_W];
    ti = r.vpage[IDX_W-1:0];
    pde = dir_model[di];
    fl = r.flags | ENTRY_P;
    pde_p = |(pde[FLAG_W-1:0] & ENTRY_P);
    pde_ps = |(pde[FLAG_W-1:0] & ENTRY_PS);
    slot = 32'(pde[ENTRY_W-1:FLAG_W]);
    slot_ok = slot < TABLE_SLOTS;
    idx = slot * DIR_ENTRIES + 32'(ti);
    te_p = slot_ok && |(tbl_model[idx][FLAG_W-1:0] & ENTRY_P);
    res.status = ST_OK;
    res.mtype = MT_NONE;
    res.frame = '0;
    if (r.kind == KIND_MAP) begin
      if (r.large_pg) begin
        // any table behind the entry is simply abandoned
        dir_model[di] = {r.frame, pde[FLAG_W-1:0] | fl | ENTRY_PS};
      end else if (pde_p && pde_ps) begin
        res.status = ST_CONFLICT;
      end else if (!pde_p && slots_taken >= TABLE_SLOTS) begin
        res.status = ST_NO_TABLE;
      end else begin
        if (!pde_p) begin
          for (int k = 0; k < DIR_ENTRIES; k++) tbl_model[slots_taken*DIR_ENTRIES+k] = '0;
          pde = {FRAME_W'(slots_taken), (pde[FLAG_W-1:0] | ENTRY_P) & ~ENTRY_PS};
          slots_taken++;
        end
        pde[FLAG_W-1:0] = pde[FLAG_W-1:0] | (fl & DIR_FLAG_MASK);
        dir_model[di] = pde;
        slot = 32'(pde[ENTRY_W-1:FLAG_W]);
        if (slot < TABLE_SLOTS) begin
          idx = slot * DIR_ENTRIES + 32'(ti);
          te = tbl_model[idx];
          tbl_model[idx] = {r.frame, te[FLAG_W-1:0] | fl};
        end
      end
    end else if (r.kind == KIND_UNMAP) begin
      if (!pde_p) begin
        res.status = ST_NOT_PRESENT;
      end else if (pde_ps) begin
        if (r.large_pg) dir_model[di] = pde & ~{{FRAME_W{1'b0}}, ENTRY_P};
        else res.status = ST_CONFLICT;
      end else if (!te_p) begin
        res.status = ST_NOT_PRESENT;
      end else begin
        tbl_model[idx] = tbl_model[idx] & ~{{FRAME_W{1'b0}}, ENTRY_P};
      end
    end else begin
      if (!pde_p) begin
        res.status = ST_NOT_PRESENT;
      end else if (pde_ps) begin
        res.mtype = MT_LARGE;
        res.frame = pde[ENTRY_W-1:FLAG_W];
      end else if (te_p) begin
        res.mtype = MT_SMALL;
        res.frame = tbl_model[idx][ENTRY_W-1:FLAG_W];
      end else begin
        res.status = ST_NOT_PRESENT;
      end
    end
  endtask

  task automatic add_req(input logic [1:0] kind, input logic [VPAGE_W-1:0] vpage,
                         input logic [FRAME_W-1:0] frame, input logic [FLAG_W-1:0] flags,
                         input logic large_pg);
    page_req_t   r;
    int unsigned n;
    n = page_reqs.size();
    r.kind = kind;
    r.vpage = vpage;
    r.frame = frame;
    r.flags = flags;
    r.large_pg = large_pg;
    r.gap = (n >= BURST_LO && n < BURST_HI) ? 0 : $urandom_range(0, 5);
    r.hold_rx = (n == HOLD_AT);
    r.settle = (n == SETTLE_AT);
    page_reqs.push_back(r);
  endtask

  task automatic build_directed();
    add_req(KIND_XLATE,     20'h00000, 20'h00000, 12'h000, 1'b0);
    add_req(KIND_UNMAP,     20'h00000, 20'h00000, 12'h000, 1'b0);
    add_req(KIND_UNMAP,     20'h00000, 20'h00000, 12'h000, 1'b1);
    add_req(KIND_MAP,       20'h00000, 20'hFFFFF, 12'hFFF, 1'b0);
    add_req(KIND_XLATE,     20'h00000, 20'h00000, 12'h000, 1'b0);
    add_req(KIND_XLATE,     20'h00001, 20'h00000, 12'h000, 1'b0);
    add_req(KIND_UNMAP,     20'h00001, 20'h00000, 12'h000, 1'b0);
    add_req(KIND_MAP,       20'h003FF, 20'h00000, 12'h000, 1'b0);
    add_req(KIND_XLATE_ALT, 20'h003FF, 20'h00000, 12'h000, 1'b0);
    // large map over a small directory entry drops its table
    add_req(KIND_MAP,       20'h00123, 20'hABCDE, 12'h000, 1'b1);
    add_req(KIND_XLATE,     20'h00005, 20'h00000, 12'h000, 1'b0);
    add_req(KIND_MAP,       20'h00001, 20'h11111, 12'h0F0, 1'b0);
    add_req(KIND_UNMAP,     20'h00000, 20'h00000, 12'h000, 1'b0);
    add_req(KIND_UNMAP,     20'h00000, 20'h00000, 12'h000, 1'b1);
    add_req(KIND_XLATE,     20'h00000, 20'h00000, 12'h000, 1'b1);
    add_req(KIND_UNMAP,     20'h00000, 20'h00000, 12'h000, 1'b1);
    // entry is absent but still has the page size bit
    add_req(KIND_MAP,       20'h00002, 20'h12345, 12'h040, 1'b0);
    add_req(KIND_XLATE_ALT, 20'h00002, 20'h00000, 12'h000, 1'b0);
    add_req(KIND_MAP,       20'hFFFFF, 20'hFFFFF, 12'hFFF, 1'b1);
    add_req(KIND_XLATE,     20'hFFFFF, 20'hFFFFF, 12'hFFF, 1'b1);
    // large unmap on a small-page directory entry hits the table entry
    add_req(KIND_UNMAP,     20'h00002, 20'h00000, 12'h000, 1'b1);
    add_req(KIND_XLATE,     20'h00002, 20'h00000, 12'h000, 1'b0);
    add_req(KIND_UNMAP,     20'h00002, 20'h00000, 12'h000, 1'b1);
    add_req(KIND_MAP,       20'hFFC00, 20'h00000, 12'h000, 1'b0);
  endtask

  // mostly map/translate/unmap/translate runs on a handful of directory
  // entries so tables fill up and the pool runs dry
  task automatic build_random();
    logic [IDX_W-1:0]   focus [24];
    logic [IDX_W-1:0]   ti;
    logic [VPAGE_W-1:0] vp;
    bit                 big;
    int unsigned        pick;
    focus[0] = '0;
    focus[1] = '1;
    for (int k = 2; k < 24; k++) focus[k] = IDX_W'($urandom_range(0, DIR_ENTRIES - 1));
    while (page_reqs.size() < REQ_TOTAL) begin
      pick = $urandom_range(0, 9);
      ti = ($urandom_range(0, 3) == 0) ? IDX_W'($urandom_range(0, 1023))
                                       : IDX_W'($urandom_range(0, 7));
      vp = {focus[$urandom_range(0, 23)], ti};
      big = ($urandom_range(0, 3) == 0);
      if (pick < 8) begin
        add_req(KIND_MAP, vp, FRAME_W'($urandom), FLAG_W'($urandom), big);
        add_req(($urandom_range(0, 7) == 0) ? KIND_XLATE_ALT : KIND_XLATE, vp,
                FRAME_W'($urandom), FLAG_W'($urandom), 1'($urandom));
        if ($urandom_range(0, 1) == 1)
          add_req(KIND_UNMAP, vp, FRAME_W'($urandom), FLAG_W'($urandom),
                  ($urandom_range(0, 4) == 0) ? !big : big);
        add_req(KIND_XLATE, vp, FRAME_W'($urandom), FLAG_W'($urandom), 1'($urandom));
      end else begin
        add_req(2'($urandom), ($urandom_range(0, 1) == 1) ? vp : VPAGE_W'($urandom),
                FRAME_W'($urandom), FLAG_W'($urandom), 1'($urandom));
      end
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      req_if.kind <= KIND_MAP;
      req_if.virt_page <= '0;
      req_if.phys_frame <= '0;
      req_if.flags <= '0;
      req_if.large_page <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      if (page_reqs.size() != 0 && idle_gap >= page_reqs[0].gap &&
          !(page_reqs[0].settle && walk_results.size() != 0)) begin
        cur = page_reqs.pop_front();
        req_if.kind <= cur.kind;
        req_if.virt_page <= cur.vpage;
        req_if.phys_frame <= cur.frame;
        req_if.flags <= cur.flags;
        req_if.large_page <= cur.large_pg;
        req_if.valid <= 1'b1;
        idle_gap = 0;
        if (cur.hold_rx) hold_kick++;
      end else begin
        req_if.valid <= 1'b0;
        idle_gap++;
      end
    end
  end

  // long result hold-off, started by a marked item
  always @(posedge clk) begin
    if (hold_kick != hold_seen) begin
      hold_seen = hold_kick;
      hold_left = HOLD_CYCLES;
    end else if (hold_left != 0) begin
      hold_left--;
    end
  end

  // result receiver
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
    end else begin
      if (rsp_taken)
        rx_wait = (results_seen >= RX_CALM_LO && results_seen < RX_CALM_HI) ? 0
                                                                          : $urandom_range(0, 5);
      else if (rx_wait != 0)
        rx_wait--;
      rsp_if.ready <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    req_taken = rst_n && req_if.valid && req_if.ready;
    rsp_taken = rst_n && rsp_if.valid && rsp_if.ready;
    if (req_taken) begin
      seen_req.kind = req_if.kind;
      seen_req.vpage = req_if.virt_page;
      seen_req.frame = req_if.phys_frame;
      seen_req.flags = req_if.flags;
      seen_req.large_pg = req_if.large_page;
      walk_request(seen_req, want);
      walk_results.push_back(want);
    end
    if (rsp_taken) begin
      results_seen++;
      if (walk_results.size() == 0) begin
        flag_mismatch("result item with no request outstanding");
      end else begin
        got = walk_results.pop_front();
        if (rsp_if.status !== got.status)
          flag_mismatch($sformatf("result %0d status %0d, wanted %0d",
                                  results_seen, rsp_if.status, got.status));
        if (rsp_if.map_type !== got.mtype)
          flag_mismatch($sformatf("result %0d map_type %0d, wanted %0d",
                                  results_seen, rsp_if.map_type, got.mtype));
        if (rsp_if.frame_out !== got.frame)
          flag_mismatch($sformatf("result %0d frame_out %05h, wanted %05h",
                                  results_seen, rsp_if.frame_out, got.frame));
      end
    end
    if (!rst_n || req_taken || rsp_taken) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $time, quiet_cycles);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_n = 1'b0;
    build_directed();
    build_random();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (page_reqs.size() != 0 || req_if.valid) @(negedge clk);
    while (walk_results.size() != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (walk_results.size() != 0)
      flag_mismatch($sformatf("%0d results never came", walk_results.size()));
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/tlpt_pkg.sv
hw/rtl/tlpt_req_if.sv
hw/rtl/tlpt_rsp_if.sv
hw/rtl/tlpt_ram.sv
hw/rtl/tlpt_ctrl.sv
hw/rtl/tlpt_dpath.sv
hw/rtl/two_level_page_table_engine.sv
test/two_level_page_table_engine_tb.sv
